// ===== sv/dbr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared constants and types for the disparity tile reduction block.
// ----------------------------------------------------------------------------
package dbr_pkg;

    localparam int TILE_SIZE = 4;
    localparam int MAX_TILES_ACROSS = 160;
    localparam int MAX_TILES_DOWN = 120;
    localparam int ROW_LEN = TILE_SIZE * MAX_TILES_ACROSS;
    localparam int STORE_DEPTH = (TILE_SIZE - 1) * ROW_LEN;
    localparam int WIN_DEPTH = TILE_SIZE * TILE_SIZE;

    localparam int DISP_W = 16;
    localparam int ACROSS_W = 8;
    localparam int DOWN_W = 7;
    localparam int WINDOW_W = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SUM_W = DISP_W + 5;
    localparam int MAG_W = SUM_W - 1;
    localparam int CNT_W = 5;

    localparam logic [ACROSS_W-1:0] ACROSS_MAX = ACROSS_W'(MAX_TILES_ACROSS);
    localparam logic [DOWN_W-1:0] DOWN_MAX = DOWN_W'(MAX_TILES_DOWN);

    localparam logic [ACROSS_W-1:0] ACROSS_RESET = 8'd160;
    localparam logic [DOWN_W-1:0] DOWN_RESET = 7'd120;
    localparam logic signed [DISP_W-1:0] MAX_VALID_RESET = 16'sd25344;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 15'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCKS_ACROSS = 2'd0,
        CFG_BLOCKS_DOWN   = 2'd1,
        CFG_MAX_VALID     = 2'd2,
        CFG_WINDOW_BELOW  = 2'd3
    } cfg_index_t;

    typedef logic signed [DISP_W-1:0] disp_t;

endpackage

// ===== sv/disparity_block_reduce_top.sv =====
// Sequence: once the bottom-right pixel of a tile is accepted, S_READ, S_MAX, S_SUM,
// S_DIV and S_DONE follow (S_SUM and S_DIV only with a valid maximum), and out_valid
// rises once the output register is free. Throughput: one pixel per cycle, except the
// bottom-right pixel of each tile, which holds the input for the tile sequence: 12 reads
// on the single line-store read port, 16-step max scan, 16-step sum, 20-step serial divide.
// Reset: position counters clear and registers take their defaults; no line-store reset.
// ----------------------------------------------------------------------------
// disparity_block_reduce_top
// Reduces a raster stream of Q8.8 disparity pixels to one value per 4x4 tile
// using a three-row line store and a sequential tile evaluator.
// ----------------------------------------------------------------------------
module disparity_block_reduce_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [dbr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dbr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [dbr_pkg::DISP_W-1:0]     disparity,
    input  logic                                  start_of_frame,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [dbr_pkg::DISP_W-1:0]     reduced_disparity,
    output logic [dbr_pkg::ACROSS_W-1:0]          tile_column,
    output logic [dbr_pkg::DOWN_W-1:0]            tile_row,
    output logic                                  last_of_frame
);
    import dbr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MAX,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [ACROSS_W-1:0]      across_reg;
    logic [DOWN_W-1:0]        down_reg;
    disp_t                    max_valid_reg;
    logic [WINDOW_W-1:0]      window_reg;
    logic [ACROSS_W-1:0]      across_c;
    logic [DOWN_W-1:0]        down_c;

    // position
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         col_c;
    logic [ROW_W-1:0]         row_c;
    logic [COL_W-1:0]         col_next;
    logic [ROW_W-1:0]         row_next;
    logic [1:0]               cp;
    logic [1:0]               rp;
    logic                     col_last;
    logic                     row_last;

    // line store
    logic signed [DISP_W-1:0] store_mem [0:STORE_DEPTH-1];
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [ADDR_W-1:0]        wr_row_off;
    logic [ADDR_W-1:0]        rd_row_off;
    disp_t                    rd_data_reg;

    // tile evaluation
    disp_t                    win_reg [0:WIN_DEPTH-1];
    logic [CNT_W-1:0]         step_reg;
    logic [ACROSS_W-1:0]      tcol_reg;
    logic [DOWN_W-1:0]        trow_reg;
    logic                     tlast_reg;
    disp_t                    best_reg;
    disp_t                    best_next;
    logic signed [DISP_W:0]   floor_reg;
    logic signed [DISP_W:0]   floor_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [MAG_W-1:0]         mag_next;
    logic                     neg_reg;
    logic [MAG_W-1:0]         dq_reg;
    logic [MAG_W-1:0]         dq_next;
    logic [CNT_W-2:0]         rem_reg;
    logic [CNT_W-2:0]         rem_next;
    logic [CNT_W-1:0]         trial;
    logic [MAG_W-1:0]         quot;
    disp_t                    res_reg;
    disp_t                    win_a;
    logic                     in_take;
    logic                     out_take;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // saturate tile counts into their legal range
    always_comb
    begin
        priority if (across_reg == '0)
            across_c = ACROSS_W'(1);
        else if (across_reg > ACROSS_MAX)
            across_c = ACROSS_MAX;
        else
            across_c = across_reg;
        priority if (down_reg == '0)
            down_c = DOWN_W'(1);
        else if (down_reg > DOWN_MAX)
            down_c = DOWN_MAX;
        else
            down_c = down_reg;
    end

    // position of the incoming pixel, wrapped into the frame
    always_comb
    begin
        if (start_of_frame || (col_reg[COL_W-1:2] >= across_c))
            col_c = '0;
        else
            col_c = col_reg;
        if (start_of_frame || (row_reg[ROW_W-1:2] >= down_c))
            row_c = '0;
        else
            row_c = row_reg;
        cp = col_c[1:0];
        rp = row_c[1:0];
        col_last = (cp == 2'd3) && (col_c[COL_W-1:2] == across_c - ACROSS_W'(1));
        row_last = (rp == 2'd3) && (row_c[ROW_W-1:2] == down_c - DOWN_W'(1));
        col_next = col_last ? '0 : col_c + COL_W'(1);
        if (col_last)
            row_next = row_last ? '0 : row_c + ROW_W'(1);
        else
            row_next = row_c;
    end

    // line store addressing
    always_comb
    begin
        unique case (rp)
            2'd0:    wr_row_off = '0;
            2'd1:    wr_row_off = ADDR_W'(ROW_LEN);
            2'd2:    wr_row_off = ADDR_W'(2 * ROW_LEN);
            default: wr_row_off = '0;
        endcase
        unique case (step_reg[3:2])
            2'd0:    rd_row_off = '0;
            2'd1:    rd_row_off = ADDR_W'(ROW_LEN);
            2'd2:    rd_row_off = ADDR_W'(2 * ROW_LEN);
            default: rd_row_off = '0;
        endcase
        mem_we = in_take && (rp != 2'd3);
        mem_waddr = wr_row_off + ADDR_W'(col_c);
        mem_raddr = rd_row_off + ADDR_W'({tcol_reg, 2'b00}) + ADDR_W'(step_reg[1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= disparity;
        rd_data_reg <= store_mem[mem_raddr];
    end

    // scan, sum and divide datapath
    always_comb
    begin
        win_a = win_reg[step_reg[3:0]];

        best_next = best_reg;
        if ((win_a <= max_valid_reg) && (win_a > best_reg))
            best_next = win_a;
        floor_next = (DISP_W+1)'(best_next) - $signed({2'b00, window_reg});

        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if ($signed({win_a[DISP_W-1], win_a}) > floor_reg)
        begin
            sum_next = sum_reg + SUM_W'(win_a);
            cnt_next = cnt_reg + CNT_W'(1);
        end
        mag_next = sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);

        // one restoring divide step: remainder stays below the count
        trial = {rem_reg, dq_reg[MAG_W-1]};
        if (trial >= cnt_reg)
        begin
            rem_next = (CNT_W-1)'(trial - cnt_reg);
            dq_next = {dq_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[CNT_W-2:0];
            dq_next = {dq_reg[MAG_W-2:0], 1'b0};
        end
        quot = neg_reg ? (MAG_W'(0) - dq_next) : dq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            across_reg <= ACROSS_RESET;
            down_reg <= DOWN_RESET;
            max_valid_reg <= MAX_VALID_RESET;
            window_reg <= WINDOW_RESET;
            col_reg <= '0;
            row_reg <= '0;
            step_reg <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            tlast_reg <= 1'b0;
            best_reg <= '0;
            floor_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
            dq_reg <= '0;
            rem_reg <= '0;
            res_reg <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
                win_reg[i] <= '0;
            out_valid <= 1'b0;
            reduced_disparity <= '0;
            tile_column <= '0;
            tile_row <= '0;
            last_of_frame <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_BLOCKS_ACROSS: across_reg <= cfg_data[ACROSS_W-1:0];
                    CFG_BLOCKS_DOWN:   down_reg <= cfg_data[DOWN_W-1:0];
                    CFG_MAX_VALID:     max_valid_reg <= cfg_data;
                    CFG_WINDOW_BELOW:  window_reg <= cfg_data[WINDOW_W-1:0];
                    default:           ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (out_take && (state_reg != S_DONE))
                out_valid <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        col_reg <= col_next;
                        row_reg <= row_next;
                        if (rp == 2'd3)
                        begin
                            win_reg[{2'd3, cp}] <= disparity;
                            if (cp == 2'd3)
                            begin
                                tcol_reg <= col_c[COL_W-1:2];
                                trow_reg <= row_c[ROW_W-1:2];
                                tlast_reg <= col_last && row_last;
                                step_reg <= '0;
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    // read data is registered: each step stores the word read at the previous step's address
                    if (step_reg != '0)
                        win_reg[step_reg[3:0] - 4'd1] <= rd_data_reg;
                    if (step_reg == CNT_W'(12))
                    begin
                        step_reg <= '0;
                        best_reg <= '0;
                        state_reg <= S_MAX;
                    end
                    else
                        step_reg <= step_reg + CNT_W'(1);
                end
                S_MAX:
                begin
                    best_reg <= best_next;
                    if (step_reg == CNT_W'(WIN_DEPTH - 1))
                    begin
                        step_reg <= '0;
                        floor_reg <= floor_next;
                        sum_reg <= '0;
                        cnt_reg <= '0;
                        if (best_next == '0)
                        begin
                            res_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_SUM;
                    end
                    else
                        step_reg <= step_reg + CNT_W'(1);
                end
                S_SUM:
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    if (step_reg == CNT_W'(WIN_DEPTH - 1))
                    begin
                        step_reg <= '0;
                        neg_reg <= sum_next[SUM_W-1];
                        dq_reg <= mag_next;
                        rem_reg <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        step_reg <= step_reg + CNT_W'(1);
                end
                S_DIV:
                begin
                    dq_reg <= dq_next;
                    rem_reg <= rem_next;
                    step_reg <= step_reg + CNT_W'(1);
                    if (step_reg == CNT_W'(MAG_W - 1))
                    begin
                        res_reg <= quot[DISP_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        reduced_disparity <= res_reg;
                        tile_column <= tcol_reg;
                        tile_row <= trow_reg;
                        last_of_frame <= tlast_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
